@@ hdl/shdbe_pkg.sv @@
// Shared types, constants and codes of the sorted hash delta bucket encoder.
package shdbe_pkg;

	localparam int HASH_BITS    = 32;
	localparam int BUCKET_BITS  = 16;
	localparam int SHIFT_BITS   = (HASH_BITS > BUCKET_BITS) ? (HASH_BITS - BUCKET_BITS) : 0;
	localparam int RESULT_LIMIT = 34;
	localparam int CHUNK_LIMIT  = 65535;

	localparam logic [31:0] HASH_MASK = (HASH_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << HASH_BITS) - 64'd1);
	localparam logic [15:0] CHUNK_MAX = 16'(CHUNK_LIMIT);
	localparam logic [31:0] DELTA_LIMIT_OPEN = 32'((RESULT_LIMIT - 1) * CHUNK_LIMIT);
	localparam logic [31:0] DELTA_LIMIT_CONT = 32'(RESULT_LIMIT * CHUNK_LIMIT);
	localparam logic [16:0] SENTINEL_BUCKET = 17'(64'd1 << BUCKET_BITS);

	localparam logic OP_HASH   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [1:0] KIND_CHUNK = 2'd0;
	localparam logic [1:0] KIND_SPAN  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef enum logic [1:0] {
		CMD_HASH,
		CMD_FINISH,
		CMD_ERROR
	} cmd_code_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] hash_value;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] chunk;
		logic [16:0] first_bucket;
		logic [16:0] last_bucket;
		logic [31:0] word_offset;
		logic        last;
	} out_t;

	typedef struct packed {
		cmd_code_t   code;
		logic        open;
		logic [16:0] first_bucket;
		logic [16:0] last_bucket;
		logic [31:0] delta;
	} cmd_t;

endpackage

@@ hdl/sorted_hash_delta_bucket_encoder.sv @@
// Top level of the sorted hash delta bucket encoder.
//
// Input channel (in_valid/in_ready/in_data): one word per hash or finish
// operation. Output channel (out_valid/out_ready/out_data): span records,
// 16-bit delta chunks and order errors; last marks the final word of an input.
// The front end accepts one word per cycle while the two-entry command queue
// has room; it updates the bucket and reference state at once.
// The back end emits one result word per cycle from the queue head while the
// output register is free or taken, so a hash that opens a bucket gives a span
// word and then its delta chunks, a hash inside the current bucket only its
// chunks, and a repeated hash none. An accepted input passes through a queue
// entry, the back end's command register and the output register before its
// first result is on the output. When out_ready is low the output register
// holds its word, the back end stops, the queue fills and in_ready drops after
// two more commands. Reset clears next bucket, reference value, word count,
// queue and output valid; no clearing pass is needed.
module sorted_hash_delta_bucket_encoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  shdbe_pkg::in_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output shdbe_pkg::out_t   out_data
);
	import shdbe_pkg::*;

	cmd_t q_push_data;
	cmd_t q_pop_data;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	shdbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.full     (q_full),
		.push     (q_push),
		.cmd      (q_push_data)
	);

	shdbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	shdbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.pop       (q_pop),
		.cmd_in    (q_pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_ERROR) |-> out_data.last)
		else $error("error word without last");

	a_chunk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_CHUNK) |-> (out_data.chunk != 16'd0))
		else $error("zero delta chunk");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_SPAN) |->
		(out_data.last_bucket >= out_data.first_bucket))
		else $error("span with reversed buckets");

endmodule

@@ hdl/shdbe_front.sv @@
// Front end: accepts words, classifies them and tracks bucket and reference state.
module shdbe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  shdbe_pkg::in_t    in_data,
	input  logic              full,
	output logic              push,
	output shdbe_pkg::cmd_t   cmd
);
	import shdbe_pkg::*;

	logic [16:0] next_q;
	logic [31:0] ref_q;
	logic [31:0] hash_m;
	logic [31:0] bucket;
	logic [31:0] base;
	logic [31:0] ref_sel;
	logic [31:0] delta;
	logic        opens;
	logic        in_bucket;
	logic        too_many;
	logic        err;
	logic        finish;
	logic        produces;
	logic        accept;

	assign hash_m    = in_data.hash_value & HASH_MASK;
	assign bucket    = hash_m >> SHIFT_BITS;
	assign base      = bucket << SHIFT_BITS;
	assign opens     = bucket >= 32'(next_q);
	assign in_bucket = (({1'b0, bucket} + 33'd1) == 33'(next_q)) && (hash_m >= ref_q);
	assign ref_sel   = opens ? base : ref_q;
	assign delta     = hash_m - ref_sel;
	assign too_many  = delta > (opens ? DELTA_LIMIT_OPEN : DELTA_LIMIT_CONT);
	assign err       = (!opens && !in_bucket) || too_many;
	assign finish    = in_data.operation == OP_FINISH;
	assign produces  = finish || err || opens || (delta != 32'd0);

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && produces;

	always_comb begin
		cmd.code         = CMD_HASH;
		cmd.open         = opens;
		cmd.first_bucket = next_q;
		cmd.last_bucket  = bucket[16:0];
		cmd.delta        = delta;
		if (finish) begin
			cmd.code        = CMD_FINISH;
			cmd.open        = 1'b0;
			cmd.last_bucket = SENTINEL_BUCKET;
			cmd.delta       = 32'd0;
		end else if (err) begin
			cmd.code = CMD_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= 17'd0;
			ref_q  <= 32'd0;
		end else if (accept) begin
			if (finish) begin
				next_q <= 17'd0;
				ref_q  <= 32'd0;
			end else if (!err) begin
				if (opens) begin
					next_q <= 17'(bucket + 32'd1);
				end
				ref_q <= hash_m;
			end
		end
	end

endmodule

@@ hdl/shdbe_queue.sv @@
// Two-entry command queue between front and back end.
module shdbe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  shdbe_pkg::cmd_t   push_data,
	input  logic              pop,
	output shdbe_pkg::cmd_t   pop_data,
	output logic              full,
	output logic              empty
);
	import shdbe_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/shdbe_back.sv @@
// Back end: commands to span/chunk/error words, one per cycle unless stalled.
module shdbe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	output logic              pop,
	input  shdbe_pkg::cmd_t   cmd_in,
	output logic              out_valid,
	input  logic              out_ready,
	output shdbe_pkg::out_t   out_data
);
	import shdbe_pkg::*;

	cmd_t        cur_q;
	logic        cur_valid_q;
	logic        span_pend_q;
	logic [31:0] word_cnt_q;
	logic        out_valid_q;
	out_t        out_q;
	out_t        res;
	logic        fin;
	logic        advance;
	logic        is_chunk;
	logic [15:0] chunk_w;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign advance   = cur_valid_q && (!out_valid_q || out_ready);
	assign pop       = !empty && (!cur_valid_q || (advance && fin));
	assign chunk_w   = (cur_q.delta > 32'(CHUNK_MAX)) ? CHUNK_MAX : cur_q.delta[15:0];

	always_comb begin
		res      = '0;
		fin      = 1'b1;
		is_chunk = 1'b0;
		unique case (cur_q.code)
			CMD_FINISH: begin
				res.kind         = KIND_SPAN;
				res.first_bucket = cur_q.first_bucket;
				res.last_bucket  = cur_q.last_bucket;
				res.word_offset  = word_cnt_q;
			end
			CMD_HASH: begin
				if (span_pend_q) begin
					res.kind         = KIND_SPAN;
					res.first_bucket = cur_q.first_bucket;
					res.last_bucket  = cur_q.last_bucket;
					res.word_offset  = word_cnt_q;
					fin              = cur_q.delta == 32'd0;
				end else begin
					is_chunk  = 1'b1;
					res.kind  = KIND_CHUNK;
					res.chunk = chunk_w;
					fin       = cur_q.delta <= 32'(CHUNK_MAX);
				end
			end
			default: begin
				res.kind = KIND_ERROR;
			end
		endcase
		res.last = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			span_pend_q <= 1'b0;
			word_cnt_q  <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (cur_q.code == CMD_FINISH) begin
					word_cnt_q <= 32'd0;
				end else if (is_chunk) begin
					word_cnt_q <= word_cnt_q + 32'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				span_pend_q <= cmd_in.open;
			end else if (advance) begin
				span_pend_q <= 1'b0;
				if (fin) begin
					cur_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
		if (pop) begin
			cur_q <= cmd_in;
		end else if (advance && is_chunk) begin
			cur_q.delta <= cur_q.delta - 32'(chunk_w);
		end
	end

endmodule

@@ tb/sv/tb_sorted_hash_delta_bucket_encoder.sv @@
// Testbench of the sorted hash delta bucket encoder: directed and random hash streams.
`timescale 1ns / 100ps

module tb_sorted_hash_delta_bucket_encoder;

	import shdbe_pkg::*;

	localparam int LONG_HOLD_CYCLES = 80;
	localparam int TAIL_CYCLES      = 10;
	localparam int WATCHDOG_CYCLES  = 2000;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data  = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// predicted encoder state
	logic [16:0] enc_next_bucket = '0;
	logic [31:0] enc_reference   = '0;
	logic [31:0] enc_word_count  = '0;
	out_t        awaited_words[$];
	out_t        head_word;

	bit tx_idle_on    = 1'b1;
	bit rx_idle_on    = 1'b1;
	int hold_requests = 0;
	int holds_started = 0;
	int rx_hold_left  = 0;
	int rx_stall;
	int mismatches    = 0;
	int idle_cycles   = 0;

	sorted_hash_delta_bucket_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic void await_word(input out_t r);
		awaited_words.insert(awaited_words.size(), r);
	endfunction

	function automatic void push_order_error();
		out_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.last = 1'b1;
		await_word(r);
	endfunction

	function automatic void encode_hash_word(input in_t w);
		logic [31:0] h;
		logic [31:0] base;
		logic [32:0] bkt;
		logic        opens;
		logic [63:0] delta;
		logic [63:0] chunks;
		logic [63:0] room;
		logic [63:0] piece;
		int          n;
		int          total;
		out_t        r;
		if (w.operation == OP_FINISH) begin
			r = '0;
			r.kind = KIND_SPAN;
			r.first_bucket = enc_next_bucket;
			r.last_bucket = SENTINEL_BUCKET;
			r.word_offset = enc_word_count;
			r.last = 1'b1;
			await_word(r);
			enc_next_bucket = '0;
			enc_reference = '0;
			enc_word_count = '0;
			return;
		end
		h = w.hash_value & HASH_MASK;
		bkt = 33'(h >> SHIFT_BITS);
		opens = (bkt >= 33'(enc_next_bucket));
		base = enc_reference;
		if (opens) begin
			base = 32'(bkt << SHIFT_BITS);
		end else if (bkt + 33'd1 != 33'(enc_next_bucket) || h < enc_reference) begin
			push_order_error();
			return;
		end
		delta = 64'(h - base);
		chunks = (delta + 64'(CHUNK_LIMIT - 1)) / 64'(CHUNK_LIMIT);
		room = 64'(RESULT_LIMIT) - (opens ? 64'd1 : 64'd0);
		if (chunks > room) begin
			push_order_error();
			return;
		end
		total = int'(chunks) + (opens ? 1 : 0);
		n = 0;
		if (opens) begin
			r = '0;
			r.kind = KIND_SPAN;
			r.first_bucket = enc_next_bucket;
			r.last_bucket = 17'(bkt);
			r.word_offset = enc_word_count;
			r.last = (total == 1);
			await_word(r);
			enc_next_bucket = 17'(bkt + 33'd1);
			n = 1;
		end
		while (delta != 0) begin
			piece = (delta < 64'(CHUNK_LIMIT)) ? delta : 64'(CHUNK_LIMIT);
			n++;
			r = '0;
			r.kind = KIND_CHUNK;
			r.chunk = 16'(piece);
			r.last = (n == total);
			await_word(r);
			delta = delta - piece;
			enc_word_count = enc_word_count + 32'd1;
		end
		enc_reference = h;
	endfunction

	function automatic in_t hash_word(input logic [31:0] h);
		in_t w;
		w.operation = OP_HASH;
		w.hash_value = h;
		return w;
	endfunction

	function automatic in_t finish_word();
		in_t w;
		w.operation = OP_FINISH;
		w.hash_value = $urandom;
		return w;
	endfunction

	function automatic in_t stream_word();
		in_t         w;
		logic [32:0] bkt;
		logic [15:0] low;
		int unsigned sel;
		int unsigned span_room;
		int unsigned step;
		logic        in_bucket;
		w.operation = OP_HASH;
		sel = $urandom_range(0, 99);
		in_bucket = (enc_next_bucket != 17'd0) &&
			(17'(enc_reference >> SHIFT_BITS) == enc_next_bucket - 17'd1);
		if (in_bucket && sel < 10) begin
			w.hash_value = enc_reference;
			return w;
		end
		if (in_bucket && sel < 55) begin
			span_room = 32'hFFFF - 32'(enc_reference[15:0]);
			if ($urandom_range(0, 3) == 0)
				step = $urandom_range(0, span_room);
			else
				step = $urandom_range(0, (span_room < 600) ? span_room : 600);
			w.hash_value = enc_reference + step;
			return w;
		end
		if (enc_next_bucket > 17'hFFFF) return finish_word();
		sel = $urandom_range(0, 99);
		if (sel < 80)
			bkt = 33'(enc_next_bucket) + 33'($urandom_range(0, 2));
		else if (sel < 95)
			bkt = 33'(enc_next_bucket) + 33'($urandom_range(3, 300));
		else
			bkt = 33'(enc_next_bucket) + 33'($urandom_range(0, 17'hFFFF - enc_next_bucket));
		if (bkt > 33'hFFFF) bkt = 33'hFFFF;
		sel = $urandom_range(0, 9);
		low = (sel < 2) ? 16'h0000 : (sel == 2) ? 16'hFFFF : 16'($urandom);
		w.hash_value = {bkt[15:0], low};
		return w;
	endfunction

	function automatic in_t noise_word();
		in_t w;
		w.operation = ($urandom_range(0, 4) == 0) ? OP_FINISH : OP_HASH;
		w.hash_value = $urandom;
		if (w.operation == OP_HASH && enc_reference != 32'd0 && $urandom_range(0, 1) == 1)
			w.hash_value = enc_reference - 32'($urandom_range(1, 32'h20000));
		return w;
	endfunction

	task automatic send_word(input in_t w);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		encode_hash_word(w);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_words.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic test_directed_cases();
		send_word(hash_word(32'h0000_0000));
		send_word(hash_word(32'h0000_0001));
		send_word(hash_word(32'h0000_FFFF));
		send_word(hash_word(32'h0000_FFFF));
		send_word(hash_word(32'h0000_FFFE));
		send_word(hash_word(32'h0003_0005));
		send_word(hash_word(32'h0001_0000));
		send_word(hash_word(32'h0003_FFFF));
		send_word(hash_word(32'h0004_0000));
		send_word(finish_word());
		send_word(hash_word(32'h1234_5678));
		send_word(finish_word());
	endtask

	task automatic test_top_bucket_edges();
		send_word(finish_word());
		send_word(hash_word(32'hFFFF_0000));
		send_word(hash_word(32'hFFFF_FFFF));
		send_word(hash_word(32'hFFFF_FFFF));
		send_word(hash_word(32'hFFFF_8000));
		send_word(hash_word(32'h0000_0000));
		send_word(finish_word());
		send_word(hash_word(32'h0000_FFFF));
		send_word(hash_word(32'hAAAA_5555));
		send_word(finish_word());
	endtask

	task automatic test_output_stall_fill();
		hold_requests++;
		tx_idle_on = 1'b0;
		repeat (16) send_word(stream_word());
		tx_idle_on = 1'b1;
		send_word(finish_word());
	endtask

	task automatic test_pause_for_drain();
		repeat (6) send_word(stream_word());
		wait_for_drain();
		repeat (6) send_word(stream_word());
		send_word(finish_word());
	endtask

	task automatic test_back_to_back();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (3) begin
			repeat (9) send_word(stream_word());
			send_word(finish_word());
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_random_streams(input int unsigned items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(3, 14);
				repeat (len) begin
					send_word(stream_word());
					sent++;
				end
				if ($urandom_range(0, 99) < 60) begin
					send_word(finish_word());
					sent++;
				end
			end else begin
				send_word(noise_word());
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (hold_requests != holds_started) begin
			out_ready <= 1'b0;
			rx_hold_left <= LONG_HOLD_CYCLES - 1;
			holds_started <= holds_started + 1;
		end else if (rx_idle_on) begin
			rx_stall = pick_gap();
			out_ready <= (rx_stall == 0);
			rx_hold_left <= (rx_stall > 0) ? rx_stall - 1 : 0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				$error("unexpected result word, kind %0d", out_data.kind);
				mismatches++;
			end else begin
				head_word = awaited_words.pop_front();
				check_field("kind", 32'(head_word.kind), 32'(out_data.kind));
				check_field("chunk", 32'(head_word.chunk), 32'(out_data.chunk));
				check_field("first_bucket", 32'(head_word.first_bucket),
					32'(out_data.first_bucket));
				check_field("last_bucket", 32'(head_word.last_bucket),
					32'(out_data.last_bucket));
				check_field("word_offset", head_word.word_offset, out_data.word_offset);
				check_field("last", 32'(head_word.last), 32'(out_data.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("[sorted_hash_delta_bucket_encoder] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_top_bucket_edges();
		test_output_stall_fill();
		test_pause_for_drain();
		test_back_to_back();
		test_random_streams(185);
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_words.size() != 0) begin
			$error("%0d result words never arrived", awaited_words.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("[sorted_hash_delta_bucket_encoder] OK");
		end else begin
			$display("[sorted_hash_delta_bucket_encoder] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/shdbe_pkg.sv
hdl/shdbe_front.sv
hdl/shdbe_queue.sv
hdl/shdbe_back.sv
hdl/sorted_hash_delta_bucket_encoder.sv
tb/sv/tb_sorted_hash_delta_bucket_encoder.sv
